// ===== design/tvfs_pkg.sv =====
package tvfs_pkg;

    // Gate capacity, fixed by the width of the gate index fields.
    localparam int MAX_GATES = 1024;

    // Three-valued logic codes.
    localparam logic [1:0] LV_ZERO = 2'd0;
    localparam logic [1:0] LV_ONE  = 2'd1;
    localparam logic [1:0] LV_X    = 2'd2;

    // Node roles.
    localparam logic [1:0] ROLE_PI = 2'd0;
    localparam logic [1:0] ROLE_PO = 2'd1;

    // Item operations.
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_FANIN  = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    // Gate kinds.
    localparam logic [3:0] KIND_NOT  = 4'd3;
    localparam logic [3:0] KIND_AND  = 4'd4;
    localparam logic [3:0] KIND_NAND = 4'd5;
    localparam logic [3:0] KIND_OR   = 4'd6;
    localparam logic [3:0] KIND_NOR  = 4'd7;
    localparam logic [3:0] KIND_XOR  = 4'd8;
    localparam logic [3:0] KIND_XNOR = 4'd9;

    // Final value of a gate from its kind and the fanin summary.
    function automatic logic [1:0] gate_result(
        input logic [3:0] kind,
        input logic       any0,
        input logic       any1,
        input logic       anyx,
        input logic       par,
        input logic [1:0] first
    );
        logic [1:0] r;
        r = LV_X;
        if (kind < KIND_NOT)
            r = first;
        else if (kind == KIND_NOT)
            r = (first == LV_ZERO) ? LV_ONE : ((first == LV_ONE) ? LV_ZERO : LV_X);
        else if (kind == KIND_AND)
            r = any0 ? LV_ZERO : (anyx ? LV_X : LV_ONE);
        else if (kind == KIND_NAND)
            r = any0 ? LV_ONE : (anyx ? LV_X : LV_ZERO);
        else if (kind == KIND_OR)
            r = any1 ? LV_ONE : (anyx ? LV_X : LV_ZERO);
        else if (kind == KIND_NOR)
            r = any1 ? LV_ZERO : (anyx ? LV_X : LV_ONE);
        else if (kind == KIND_XOR)
            r = anyx ? LV_X : {1'b0, par};
        else if (kind == KIND_XNOR)
            r = anyx ? LV_X : {1'b0, ~par};
        return r;
    endfunction

endpackage

// ===== design/tvfs_ram.sv =====
module tvfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== design/three_valued_fault_simulator.sv =====
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | mode ... stuck_value
// out     | output    | out_valid/stall | output_value, output_number, last_output
// cfg     | input     | cfg_valid/ready | cfg_data (gates_in_use)
// Loads and value sets leave the block idle. After reset the input stalls
// while a clearing pass sets every value to unknown. A run, once accepted,
// reads each gate's header and then its fanins one at a time in the
// evaluation pass (a gate of input role or with no fanins reads none), then
// checks every gate in the output pass, and ends by holding the last output
// when the run has outputs; the single read port of each memory sets this pacing.
// Output stall holds the output pass. Reset is asynchronous and clears
// control state only.
module three_valued_fault_simulator #(
    parameter int MAX_FANIN   = 8,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [9:0]  gate_index,
    input  logic [3:0]  gate_kind,
    input  logic [1:0]  node_role,
    input  logic [3:0]  fanin_count,
    input  logic [2:0]  fanin_slot,
    input  logic [9:0]  fanin_gate,
    input  logic [1:0]  logic_value,
    input  logic        fault_enable,
    input  logic [9:0]  fault_gate,
    input  logic        stuck_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  output_value,
    output logic [5:0]  output_number,
    output logic        last_output,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int MAX_GATES = tvfs_pkg::MAX_GATES;
    localparam int GW = $clog2(MAX_GATES);
    localparam int FW = $clog2(MAX_GATES * MAX_FANIN);
    localparam int CW = $clog2(MAX_GATES + 1);
    localparam int NW = $clog2(MAX_FANIN + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HDR, S_HDRW, S_FIN, S_FINW, S_VAL, S_EVAL, S_WB,
        S_ORD, S_OCHK, S_OHOLD
    } state_t;

    state_t       state_reg;
    logic [CW-1:0] used_reg;
    logic [GW-1:0] g_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] i_reg;
    logic [3:0]   kind_reg;
    logic [1:0]   role_reg;
    logic         any0_reg, any1_reg, anyx_reg, par_reg;
    logic [1:0]   first_reg;
    logic         fen_reg, fsv_reg;
    logic [9:0]   fg_reg;
    logic [9:0]   src_reg;
    logic         pend_reg;
    logic [6:0]   nout_reg;
    logic [1:0]   pval_reg;
    logic [1:0]   hval_reg;
    logic         out_valid_reg;
    logic [1:0]   ov_reg;
    logic [5:0]   on_reg;
    logic         ol_reg;

    // Memory ports.
    logic          k_we, r_we, c_we, f_we, v_we;
    logic [GW-1:0] h_waddr, h_raddr, v_waddr, v_raddr;
    logic [FW-1:0] f_waddr, f_raddr;
    logic [3:0]    k_rd, c_rd;
    logic [1:0]    r_rd, v_rd, v_wdata;
    logic [9:0]    f_rd;

    tvfs_ram #(.WIDTH(4), .DEPTH(MAX_GATES)) u_kind (
        .clk(clk), .we(k_we), .waddr(h_waddr), .wdata(gate_kind),
        .raddr(h_raddr), .rdata(k_rd));
    tvfs_ram #(.WIDTH(2), .DEPTH(MAX_GATES)) u_role (
        .clk(clk), .we(r_we), .waddr(h_waddr), .wdata(node_role),
        .raddr(h_raddr), .rdata(r_rd));
    tvfs_ram #(.WIDTH(4), .DEPTH(MAX_GATES)) u_count (
        .clk(clk), .we(c_we), .waddr(h_waddr), .wdata(fanin_count),
        .raddr(h_raddr), .rdata(c_rd));
    tvfs_ram #(.WIDTH(10), .DEPTH(MAX_GATES * MAX_FANIN)) u_fanin (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(fanin_gate),
        .raddr(f_raddr), .rdata(f_rd));
    tvfs_ram #(.WIDTH(2), .DEPTH(MAX_GATES)) u_value (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rd));

    logic          accept;
    logic          gi_ok, slot_ok;
    logic [CW-1:0] used_lim;
    logic [NW-1:0] cnt_lim;
    logic          src_ok;
    logic [1:0]    fin_v;
    logic [1:0]    eval_v;
    logic          fault_hit;
    logic [1:0]    wb_v;
    logic [1:0]    lv_sat;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign output_value  = ov_reg;
    assign output_number = on_reg;
    assign last_output   = ol_reg;

    assign gi_ok   = ({22'd0, gate_index} < 32'(MAX_GATES));
    assign slot_ok = ({29'd0, fanin_slot} < 32'(MAX_FANIN));
    assign used_lim = ({21'd0, cfg_data} > 32'(MAX_GATES)) ? CW'(MAX_GATES)
                                                          : CW'(cfg_data);
    assign cnt_lim = ({28'd0, c_rd} > 32'(MAX_FANIN)) ? NW'(MAX_FANIN) : NW'(c_rd);
    assign lv_sat = (logic_value > tvfs_pkg::LV_X) ? tvfs_pkg::LV_X : logic_value;

    // Fanin value: out of range reads unknown; the value memory read returns
    // the entry addressed in the previous cycle, whose index src_reg now holds.
    assign src_ok = ({22'd0, src_reg} < 32'(used_reg));
    assign fin_v  = src_ok ? v_rd : tvfs_pkg::LV_X;

    assign eval_v = (n_reg == '0) ? pval_reg :
        tvfs_pkg::gate_result(kind_reg, any0_reg, any1_reg, anyx_reg, par_reg,
                              first_reg);
    assign fault_hit = fen_reg && ({22'd0, fg_reg} == 32'(g_reg));
    assign wb_v = fault_hit ? {1'b0, fsv_reg} :
                  ((role_reg != tvfs_pkg::ROLE_PI) ? eval_v : pval_reg);

    // Memory addressing by state.
    always_comb
    begin
        k_we = 1'b0; r_we = 1'b0; c_we = 1'b0; f_we = 1'b0; v_we = 1'b0;
        h_waddr = gate_index[GW-1:0];
        h_raddr = g_reg;
        f_waddr = FW'(gate_index[GW-1:0]) * FW'(MAX_FANIN) + FW'(fanin_slot);
        f_raddr = FW'(g_reg) * FW'(MAX_FANIN) + FW'(i_reg);
        v_waddr = gate_index[GW-1:0];
        v_wdata = lv_sat;
        v_raddr = g_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                v_we = 1'b1; v_waddr = g_reg; v_wdata = tvfs_pkg::LV_X;
            end
            S_IDLE:
            begin
                if (accept && gi_ok)
                begin
                    k_we = (mode == tvfs_pkg::MODE_HEADER);
                    r_we = k_we; c_we = k_we;
                    f_we = (mode == tvfs_pkg::MODE_FANIN) && slot_ok;
                    v_we = (mode == tvfs_pkg::MODE_SET);
                end
                h_raddr = '0;
                v_raddr = '0;
            end
            S_FINW: v_raddr = f_rd[GW-1:0];
            S_WB:
            begin
                v_we = 1'b1; v_waddr = g_reg; v_wdata = wb_v;
            end
            default: ;
        endcase
    end

    // Sequencer: evaluation pass, then output pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            used_reg      <= '0;
            g_reg         <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            nout_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                used_reg <= used_lim;
            unique case (state_reg)
                S_CLEAR:
                begin
                    g_reg <= g_reg + 1'b1;
                    if (32'(g_reg) == MAX_GATES - 1)
                    begin
                        g_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    g_reg <= '0;
                    if (accept && mode == tvfs_pkg::MODE_RUN)
                    begin
                        fen_reg  <= fault_enable;
                        fg_reg   <= fault_gate;
                        fsv_reg  <= stuck_value;
                        nout_reg <= '0;
                        pend_reg <= 1'b0;
                        state_reg <= (used_reg == '0) ? S_IDLE : S_HDR;
                    end
                end
                S_HDR: state_reg <= S_HDRW;
                S_HDRW:
                begin
                    kind_reg <= k_rd;
                    role_reg <= r_rd;
                    n_reg    <= cnt_lim;
                    pval_reg <= v_rd;
                    i_reg    <= '0;
                    any0_reg <= 1'b0; any1_reg <= 1'b0;
                    anyx_reg <= 1'b0; par_reg  <= 1'b0;
                    state_reg <= (cnt_lim == '0 || r_rd == tvfs_pkg::ROLE_PI)
                                 ? S_WB : S_FIN;
                end
                S_FIN: state_reg <= S_FINW;
                S_FINW:
                begin
                    src_reg   <= f_rd;
                    state_reg <= S_VAL;
                end
                S_VAL:
                begin
                    if (i_reg == '0)
                        first_reg <= fin_v;
                    if (fin_v == tvfs_pkg::LV_ZERO)
                        any0_reg <= 1'b1;
                    else if (fin_v == tvfs_pkg::LV_ONE)
                    begin
                        any1_reg <= 1'b1;
                        par_reg  <= ~par_reg;
                    end
                    else
                        anyx_reg <= 1'b1;
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == n_reg) ? S_EVAL : S_FIN;
                end
                S_EVAL: state_reg <= S_WB;
                S_WB:
                begin
                    g_reg <= g_reg + 1'b1;
                    if (32'(g_reg) + 1 == 32'(used_reg))
                    begin
                        g_reg <= '0;
                        state_reg <= S_ORD;
                    end
                    else
                        state_reg <= S_HDR;
                end
                S_ORD: state_reg <= S_OCHK;
                S_OCHK:
                begin
                    // A found output is held until the next one (or the end)
                    // shows which is last.
                    state_reg <= S_ORD;
                    if (r_rd == tvfs_pkg::ROLE_PO && 32'(nout_reg) < MAX_OUTPUTS)
                    begin
                        if (pend_reg)
                        begin
                            if (!out_valid_reg || !out_stall)
                            begin
                                out_valid_reg <= 1'b1;
                                ov_reg <= hval_reg;
                                on_reg <= 6'(nout_reg - 7'd1);
                                ol_reg <= 1'b0;
                                hval_reg <= v_rd;
                                nout_reg <= nout_reg + 1'b1;
                            end
                            else
                                state_reg <= S_OCHK;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                            hval_reg <= v_rd;
                            nout_reg <= nout_reg + 1'b1;
                        end
                    end
                    if (state_reg != S_OCHK || !(r_rd == tvfs_pkg::ROLE_PO
                        && 32'(nout_reg) < MAX_OUTPUTS && pend_reg
                        && out_valid_reg && out_stall))
                    begin
                        if (32'(g_reg) + 1 == 32'(used_reg))
                            state_reg <= pend_reg || (r_rd == tvfs_pkg::ROLE_PO
                                && 32'(nout_reg) < MAX_OUTPUTS) ? S_OHOLD : S_IDLE;
                        else
                            g_reg <= g_reg + 1'b1;
                    end
                end
                S_OHOLD:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        ov_reg <= hval_reg;
                        on_reg <= 6'(nout_reg - 7'd1);
                        ol_reg <= 1'b1;
                        pend_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Results appear only while a run's output pass is active.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_OCHK || $past(state_reg) == S_OHOLD))
        else $error("result raised outside the output pass");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid
            && $stable({output_value, output_number, last_output})))
        else $error("stalled result changed or dropped");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item taken while busy");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // One input item, one field per port.
    typedef struct {
        logic [1:0] mode;
        logic [9:0] gate_index;
        logic [3:0] gate_kind;
        logic [1:0] node_role;
        logic [3:0] fanin_count;
        logic [2:0] fanin_slot;
        logic [9:0] fanin_gate;
        logic [1:0] logic_value;
        logic       fault_enable;
        logic [9:0] fault_gate;
        logic       stuck_value;
    } gate_item_t;

    // One primary output report.
    typedef struct {
        logic [1:0] value;
        logic [5:0] number;
        logic       last;
    } po_report_t;

    localparam int NUM_GATES   = 1024;
    localparam int FANIN_SLOTS = 8;
    localparam int PO_LIMIT    = 64;
    localparam int WIDE_GATES  = 67;
    localparam logic [1:0] ROLE_INTERNAL = 2'd2;
    localparam logic [3:0] KIND_INPUT    = 4'd0;
    localparam logic [3:0] KIND_BRANCH   = 4'd1;
    localparam logic [3:0] KIND_BUFFER   = 4'd2;
    localparam logic [3:0] KIND_BOGUS    = 4'd12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [9:0]  gate_index;
    logic [3:0]  gate_kind;
    logic [1:0]  node_role;
    logic [3:0]  fanin_count;
    logic [2:0]  fanin_slot;
    logic [9:0]  fanin_gate;
    logic [1:0]  logic_value;
    logic        fault_enable;
    logic [9:0]  fault_gate;
    logic        stuck_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  output_value;
    logic [5:0]  output_number;
    logic        last_output;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    // Shadow copy of the netlist held by the block.
    logic [3:0]  shadow_kind [NUM_GATES];
    logic [1:0]  shadow_role [NUM_GATES];
    logic [3:0]  shadow_count [NUM_GATES];
    logic [9:0]  shadow_fanin [NUM_GATES][FANIN_SLOTS];
    logic [1:0]  shadow_value [NUM_GATES];
    logic [10:0] shadow_gate_limit;

    po_report_t  pending_reports[$];
    int          mismatch_count;
    int          reports_checked;
    int          items_sent;
    int          runs_sent;
    int          out_hold_cycles;
    bit          calm;

    three_valued_fault_simulator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .gate_index    (gate_index),
        .gate_kind     (gate_kind),
        .node_role     (node_role),
        .fanin_count   (fanin_count),
        .fanin_slot    (fanin_slot),
        .fanin_gate    (fanin_gate),
        .logic_value   (logic_value),
        .fault_enable  (fault_enable),
        .fault_gate    (fault_gate),
        .stuck_value   (stuck_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .output_value  (output_value),
        .output_number (output_number),
        .last_output   (last_output),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Number of gates a run actually visits.
    function automatic int active_gates();
        return (shadow_gate_limit > NUM_GATES) ? NUM_GATES : int'(shadow_gate_limit);
    endfunction

    function automatic logic [1:0] fetch_fanin(input logic [9:0] src);
        if (int'(src) >= active_gates())
            return tvfs_pkg::LV_X;
        return shadow_value[src];
    endfunction

    // Three-valued evaluation of one gate from the shadow netlist.
    function automatic logic [1:0] evaluate_gate(input int g);
        int         n;
        logic [1:0] v;
        logic       any0;
        logic       any1;
        logic       anyx;
        logic       par;
        n = int'(shadow_count[g]);
        any0 = 1'b0;
        any1 = 1'b0;
        anyx = 1'b0;
        par = 1'b0;
        if (n > FANIN_SLOTS)
            n = FANIN_SLOTS;
        if (n == 0)
            return shadow_value[g];
        if (shadow_kind[g] <= tvfs_pkg::KIND_NOT)
        begin
            v = fetch_fanin(shadow_fanin[g][0]);
            if (shadow_kind[g] != tvfs_pkg::KIND_NOT)
                return v;
            return (v == tvfs_pkg::LV_ZERO) ? tvfs_pkg::LV_ONE :
                   ((v == tvfs_pkg::LV_ONE) ? tvfs_pkg::LV_ZERO : tvfs_pkg::LV_X);
        end
        for (int i = 0; i < n; i++)
        begin
            v = fetch_fanin(shadow_fanin[g][i]);
            if (v == tvfs_pkg::LV_ZERO)
                any0 = 1'b1;
            else if (v == tvfs_pkg::LV_ONE)
            begin
                any1 = 1'b1;
                par = ~par;
            end
            else
                anyx = 1'b1;
        end
        case (shadow_kind[g])
            tvfs_pkg::KIND_AND:
                return any0 ? tvfs_pkg::LV_ZERO : (anyx ? tvfs_pkg::LV_X : tvfs_pkg::LV_ONE);
            tvfs_pkg::KIND_NAND:
                return any0 ? tvfs_pkg::LV_ONE : (anyx ? tvfs_pkg::LV_X : tvfs_pkg::LV_ZERO);
            tvfs_pkg::KIND_OR:
                return any1 ? tvfs_pkg::LV_ONE : (anyx ? tvfs_pkg::LV_X : tvfs_pkg::LV_ZERO);
            tvfs_pkg::KIND_NOR:
                return any1 ? tvfs_pkg::LV_ZERO : (anyx ? tvfs_pkg::LV_X : tvfs_pkg::LV_ONE);
            tvfs_pkg::KIND_XOR:
                return anyx ? tvfs_pkg::LV_X : {1'b0, par};
            tvfs_pkg::KIND_XNOR:
                return anyx ? tvfs_pkg::LV_X : {1'b0, ~par};
            default:
                return tvfs_pkg::LV_X;
        endcase
    endfunction

    // Apply one accepted item to the shadow state and queue the reports it causes.
    function automatic void simulate_item(input gate_item_t it);
        int         used;
        int         nout;
        po_report_t rep;
        case (it.mode)
            tvfs_pkg::MODE_HEADER:
            begin
                shadow_kind[it.gate_index] = it.gate_kind;
                shadow_role[it.gate_index] = it.node_role;
                shadow_count[it.gate_index] = it.fanin_count;
            end
            tvfs_pkg::MODE_FANIN:
                shadow_fanin[it.gate_index][it.fanin_slot] = it.fanin_gate;
            tvfs_pkg::MODE_SET:
                shadow_value[it.gate_index] = (it.logic_value > tvfs_pkg::LV_X)
                                              ? tvfs_pkg::LV_X : it.logic_value;
            default:
            begin
                used = active_gates();
                for (int g = 0; g < used; g++)
                begin
                    if (shadow_role[g] != tvfs_pkg::ROLE_PI)
                        shadow_value[g] = evaluate_gate(g);
                    if (it.fault_enable && g == int'(it.fault_gate))
                        shadow_value[g] = {1'b0, it.stuck_value};
                end
                nout = 0;
                for (int g = 0; g < used && nout < PO_LIMIT; g++)
                begin
                    if (shadow_role[g] == tvfs_pkg::ROLE_PO)
                    begin
                        rep.value = shadow_value[g];
                        rep.number = nout[5:0];
                        rep.last = 1'b0;
                        pending_reports.insert(pending_reports.size(), rep);
                        nout++;
                    end
                end
                if (nout > 0)
                    pending_reports[pending_reports.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // Every field random; callers override what matters.
    function automatic gate_item_t random_item();
        gate_item_t it;
        it.mode = 2'($urandom_range(3));
        it.gate_index = 10'($urandom);
        it.gate_kind = 4'($urandom);
        it.node_role = 2'($urandom);
        it.fanin_count = 4'($urandom);
        it.fanin_slot = 3'($urandom);
        it.fanin_gate = 10'($urandom);
        it.logic_value = 2'($urandom);
        it.fault_enable = 1'($urandom);
        it.fault_gate = 10'($urandom);
        it.stuck_value = 1'($urandom);
        return it;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input gate_item_t it);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        mode <= it.mode;
        gate_index <= it.gate_index;
        gate_kind <= it.gate_kind;
        node_role <= it.node_role;
        fanin_count <= it.fanin_count;
        fanin_slot <= it.fanin_slot;
        fanin_gate <= it.fanin_gate;
        logic_value <= it.logic_value;
        fault_enable <= it.fault_enable;
        fault_gate <= it.fault_gate;
        stuck_value <= it.stuck_value;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        simulate_item(it);
        items_sent++;
    endtask

    task automatic load_header(input int g, input logic [3:0] kind, input logic [1:0] role,
                               input logic [3:0] cnt);
        gate_item_t it;
        it = random_item();
        it.mode = tvfs_pkg::MODE_HEADER;
        it.gate_index = 10'(g);
        it.gate_kind = kind;
        it.node_role = role;
        it.fanin_count = cnt;
        send_item(it);
    endtask

    task automatic load_fanin(input int g, input int slot, input int src);
        gate_item_t it;
        it = random_item();
        it.mode = tvfs_pkg::MODE_FANIN;
        it.gate_index = 10'(g);
        it.fanin_slot = 3'(slot);
        it.fanin_gate = 10'(src);
        send_item(it);
    endtask

    task automatic set_value(input int g, input logic [1:0] lv);
        gate_item_t it;
        it = random_item();
        it.mode = tvfs_pkg::MODE_SET;
        it.gate_index = 10'(g);
        it.logic_value = lv;
        send_item(it);
    endtask

    task automatic start_run(input logic fault_on, input int fg, input logic sv);
        gate_item_t it;
        it = random_item();
        it.mode = tvfs_pkg::MODE_RUN;
        it.fault_enable = fault_on;
        it.fault_gate = 10'(fg);
        it.stuck_value = sv;
        send_item(it);
        runs_sent++;
    endtask

    // Drop valid, wait for every report, then cover a run with no outputs.
    task automatic wait_idle();
        int guard;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        guard = 32 * active_gates() + 40;
        repeat (guard) @(negedge clk);
    endtask

    task automatic write_gate_limit(input logic [10:0] n);
        wait_idle();
        cfg_data <= n;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_gate_limit = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Checker: each accepted report against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected output item: value %0d number %0d last %0d",
                             output_value, output_number, last_output);
            end
            else
            begin
                po_report_t exp_rep;
                exp_rep = pending_reports.pop_front();
                reports_checked++;
                if (output_value !== exp_rep.value || output_number !== exp_rep.number
                    || last_output !== exp_rep.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Output mismatch: expected value %0d number %0d last %0d,",
                                  " got value %0d number %0d last %0d"},
                                 exp_rep.value, exp_rep.number, exp_rep.last,
                                 output_value, output_number, last_output);
                end
            end
        end
    end

    // Receiver stall: a long hold when requested, else rare random stalls unless calm.
    always @(negedge clk)
    begin
        if (out_hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            out_hold_cycles <= out_hold_cycles - 1;
        end
        else
            out_stall <= (!calm && $urandom_range(99) < 6);
    end

    // Each gate kind, roles, unknown kinds, out-of-range fanins and faults.
    task automatic test_directed();
        load_header(0, KIND_INPUT, tvfs_pkg::ROLE_PI, 4'd0);
        load_header(1, KIND_INPUT, tvfs_pkg::ROLE_PI, 4'd0);
        load_header(2, KIND_BRANCH, tvfs_pkg::ROLE_PO, 4'd1);
        load_fanin(2, 0, 0);
        load_header(3, tvfs_pkg::KIND_NOT, 2'd3, 4'd1);
        load_fanin(3, 0, 1);
        load_header(4, tvfs_pkg::KIND_AND, tvfs_pkg::ROLE_PO, 4'd2);
        load_fanin(4, 0, 0);
        load_fanin(4, 1, 3);
        load_header(5, tvfs_pkg::KIND_XOR, tvfs_pkg::ROLE_PO, 4'd15);
        for (int s = 0; s < FANIN_SLOTS; s++)
            load_fanin(5, s, s % 5);
        load_header(6, KIND_BOGUS, tvfs_pkg::ROLE_PO, 4'd1);
        load_fanin(6, 0, 1023);
        load_header(7, KIND_BUFFER, tvfs_pkg::ROLE_PO, 4'd0);
        write_gate_limit(11'd8);
        set_value(0, tvfs_pkg::LV_ZERO);
        set_value(1, tvfs_pkg::LV_ONE);
        set_value(7, 2'd3);
        start_run(1'b0, 0, 1'b0);
        set_value(0, tvfs_pkg::LV_X);
        start_run(1'b1, 0, 1'b1);
        start_run(1'b1, 1023, 1'b0);
        for (int k = tvfs_pkg::KIND_NAND; k <= tvfs_pkg::KIND_XNOR; k++)
        begin
            load_header(4, 4'(k), tvfs_pkg::ROLE_PO, 4'd2);
            start_run(1'b1, 3, 1'(k));
        end
        write_gate_limit(11'd0);
        start_run(1'b0, 0, 1'b0);
    endtask

    // Small random netlists, mostly well formed, with stray items in between.
    task automatic test_random_netlists();
        int n;
        int nets;
        nets = 0;
        while (items_sent < 45 && nets < 40)
        begin
            n = $urandom_range(2, 6);
            for (int g = 0; g < n; g++)
            begin
                logic [3:0] cnt;
                logic [3:0] kind;
                kind = ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
                cnt = ($urandom_range(7) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 4));
                load_header(g, kind, 2'($urandom), cnt);
                for (int s = 0; s < ((cnt > FANIN_SLOTS) ? FANIN_SLOTS : cnt); s++)
                    load_fanin(g, s, ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                              : $urandom_range(n - 1));
            end
            write_gate_limit(11'(($urandom_range(3) == 0) ? n - 1 : n));
            repeat ($urandom_range(1, 2))
            begin
                for (int g = 0; g < n; g++)
                    if ($urandom_range(1))
                        set_value(g, 2'($urandom));
                if ($urandom_range(4) == 0)
                    set_value($urandom_range(1023), 2'($urandom));
                if ($urandom_range(4) == 0)
                    load_header($urandom_range(100, 1023), 4'($urandom), 2'($urandom), 4'd0);
                if ($urandom_range(1))
                    start_run(1'b1, $urandom_range(n - 1), 1'($urandom));
                else
                    start_run(1'b0, $urandom_range(1023), 1'($urandom));
            end
            nets++;
        end
    endtask

    // Netlist with more outputs than can be reported, with a long receiver hold.
    task automatic test_full_netlist();
        for (int g = 0; g < WIDE_GATES; g++)
        begin
            logic [1:0] role;
            role = (g == 0 || g == WIDE_GATES - 1) ? tvfs_pkg::ROLE_PI : tvfs_pkg::ROLE_PO;
            load_header(g, (g == 5) ? tvfs_pkg::KIND_NAND : 4'($urandom_range(0, 9)), role,
                        (g == 5) ? 4'd2 : 4'd0);
        end
        load_fanin(5, 0, WIDE_GATES - 1);
        load_fanin(5, 1, 0);
        write_gate_limit(11'(WIDE_GATES));
        set_value(WIDE_GATES - 1, tvfs_pkg::LV_ONE);
        set_value(0, tvfs_pkg::LV_ONE);
        start_run(1'b0, 0, 1'b0);

        // Long hold on the output while the sender keeps offering items.
        wait_idle();
        out_hold_cycles = 600;
        start_run(1'b1, WIDE_GATES - 1, 1'b0);
        for (int k = 0; k < 3; k++)
            set_value($urandom_range(WIDE_GATES - 1), 2'($urandom));
        start_run(1'b1, 19, 1'b1);

        calm = 1'b1;
        start_run(1'b1, 1023, 1'b0);
        wait_idle();
        calm = 1'b0;
        write_gate_limit(11'd0);
        start_run(1'b1, 5, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = tvfs_pkg::MODE_HEADER;
        gate_index = '0;
        gate_kind = '0;
        node_role = '0;
        fanin_count = '0;
        fanin_slot = '0;
        fanin_gate = '0;
        logic_value = '0;
        fault_enable = 1'b0;
        fault_gate = '0;
        stuck_value = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        reports_checked = 0;
        items_sent = 0;
        runs_sent = 0;
        out_hold_cycles = 0;
        calm = 1'b0;
        shadow_gate_limit = '0;
        for (int g = 0; g < NUM_GATES; g++)
            shadow_value[g] = tvfs_pkg::LV_X;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_netlists();
        test_full_netlist();
        wait_idle();

        $display("Sent %0d items including %0d runs; checked %0d output items.",
                 items_sent, runs_sent, reports_checked);
        $display("Covered all gate kinds, faults, unknown fanins and output truncation.");
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #4000000;
        $display("Timeout: simulation did not finish in time.");
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tvfs_pkg.sv
design/tvfs_ram.sv
design/three_valued_fault_simulator.sv
tb/testbench.sv
